FILE: rtl/ate_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ate_pkg: shared types and helpers of the truecolor pixel encoder
// Job descriptor handed from the front end to the byte sequencer, character
// codes, and the binary to decimal digit conversion.
// ----------------------------------------------------------------------------
package ate_pkg;

  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_LBR   = 8'h5B;  // '['
  localparam logic [7:0] CH_SEMI  = 8'h3B;  // ';'
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_M     = 8'h6D;  // 'm'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_TWO   = 8'h32;  // '2'
  localparam logic [7:0] CH_FOUR  = 8'h34;  // '4'
  localparam logic [7:0] CH_EIGHT = 8'h38;  // '8'

  localparam int QueueDepth = 2;

  typedef logic [3:0] digit_t;
  typedef logic [1:0] dig_idx_t;

  // Decimal form of one color component: dig[0] ones, dig[1] tens,
  // dig[2] hundreds; top is the index of the first digit to send.
  typedef struct packed {
    digit_t [2:0] dig;
    dig_idx_t     top;
  } dec_t;

  typedef struct packed {
    logic emit_color;
    dec_t red;
    dec_t green;
    dec_t blue;
    logic line_end;
    logic frame_end;
  } job_t;

  // Double dabble: eight shift steps over a 20-bit scratch word
  function automatic dec_t to_dec(logic [7:0] v);
    logic [19:0] sc;
    dec_t        d;
    sc = {12'd0, v};
    for (int i = 0; i < 8; i++) begin
      if (sc[11:8] >= 4'd5) sc[11:8] = sc[11:8] + 4'd3;
      if (sc[15:12] >= 4'd5) sc[15:12] = sc[15:12] + 4'd3;
      if (sc[19:16] >= 4'd5) sc[19:16] = sc[19:16] + 4'd3;
      sc = {sc[18:0], 1'b0};
    end
    d.dig[0] = sc[11:8];
    d.dig[1] = sc[15:12];
    d.dig[2] = sc[19:16];
    if (sc[19:16] != 4'd0) begin
      d.top = 2'd2;
    end else if (sc[15:12] != 4'd0) begin
      d.top = 2'd1;
    end else begin
      d.top = 2'd0;
    end
    return d;
  endfunction

endpackage

FILE: rtl/ate_pixel_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ate_pixel_if: pixel input channel
// Valid/ready channel carrying one RGB pixel with its line and frame marks.
// ----------------------------------------------------------------------------
interface ate_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_level;
  logic [7:0] green_level;
  logic [7:0] blue_level;
  logic       line_end;
  logic       frame_end;

  modport source (
    output valid, red_level, green_level, blue_level, line_end, frame_end,
    input  ready
  );
  modport sink (
    input  valid, red_level, green_level, blue_level, line_end, frame_end,
    output ready
  );
endinterface

FILE: rtl/ate_text_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ate_text_if: text byte output channel
// Valid/ready channel carrying one output byte and its end-of-pixel mark.
// ----------------------------------------------------------------------------
interface ate_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last_byte;

  modport source (output valid, text_byte, last_byte, input ready);
  modport sink (input valid, text_byte, last_byte, output ready);
endinterface

FILE: rtl/ate_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ate_front: pixel classifier
// Compares each pixel with the last emitted color, converts the components
// to decimal digits and pushes one job per pixel into the queue.
// ----------------------------------------------------------------------------
module ate_front (
  input  logic          clk,
  input  logic          rst,
  ate_pixel_if.sink     pixel,
  input  logic          q_full,
  output logic          q_push,
  output ate_pkg::job_t q_job
);

  logic       color_known;
  logic [7:0] prev_red;
  logic [7:0] prev_green;
  logic [7:0] prev_blue;
  logic       emit;
  logic       eol;

  // Accept whenever the queue has room
  assign pixel.ready = !q_full;
  assign q_push      = pixel.valid && !q_full;

  // Classify the pixel
  assign emit = !color_known || (pixel.red_level != prev_red) ||
                (pixel.green_level != prev_green) || (pixel.blue_level != prev_blue);
  assign eol  = pixel.line_end || pixel.frame_end;

  always_comb begin
    q_job.emit_color = emit;
    q_job.red        = ate_pkg::to_dec(pixel.red_level);
    q_job.green      = ate_pkg::to_dec(pixel.green_level);
    q_job.blue       = ate_pkg::to_dec(pixel.blue_level);
    q_job.line_end   = eol;
    q_job.frame_end  = pixel.frame_end;
  end

  // Track the last emitted color; forget it at a line end
  always_ff @(posedge clk) begin
    if (rst) begin
      color_known <= 1'b0;
      prev_red    <= 8'd0;
      prev_green  <= 8'd0;
      prev_blue   <= 8'd0;
    end else if (q_push) begin
      if (emit) begin
        prev_red   <= pixel.red_level;
        prev_green <= pixel.green_level;
        prev_blue  <= pixel.blue_level;
      end
      color_known <= !eol;
    end
  end

endmodule

FILE: rtl/ate_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ate_queue: job queue
// Small first-in first-out buffer of job descriptors between the front end
// and the byte sequencer.
// ----------------------------------------------------------------------------
module ate_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ate_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output ate_pkg::job_t head_job
);

  localparam int PtrW = $clog2(ate_pkg::QueueDepth);
  localparam int CntW = $clog2(ate_pkg::QueueDepth + 1);

  ate_pkg::job_t       mem [ate_pkg::QueueDepth];
  logic [PtrW-1:0]     wr_ptr;
  logic [PtrW-1:0]     rd_ptr;
  logic [CntW-1:0]     count;
  logic                do_push;
  logic                do_pop;

  assign full       = (count == CntW'(ate_pkg::QueueDepth));
  assign head_valid = (count != '0);
  assign head_job   = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_job;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(ate_pkg::QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(ate_pkg::QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/ate_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ate_back: byte sequencer
// Walks one job through its escape sequence, space, newline and reset
// sequence, one byte per transfer into a registered output stage.
// ----------------------------------------------------------------------------
module ate_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  ate_pkg::job_t q_job,
  output logic          q_pop,
  ate_text_if.source    text
);

  typedef enum logic [4:0] {
    S_ESC, S_LBR, S_C4, S_C8, S_SEMI1, S_C2, S_SEMI2, S_RDIG, S_SEMI3, S_GDIG,
    S_SEMI4, S_BDIG, S_M, S_SPACE, S_NL, S_FESC, S_FLBR, S_F0, S_FM
  } step_t;

  step_t              step;
  step_t              step_next;
  ate_pkg::dig_idx_t  didx;
  ate_pkg::dig_idx_t  didx_next;
  logic               busy;
  ate_pkg::job_t      job;
  logic               load;
  logic               fin;
  logic [7:0]         cur_byte;
  ate_pkg::digit_t    cur_dig;
  logic               out_valid;
  logic [7:0]         out_byte;
  logic               out_last;

  assign text.valid     = out_valid;
  assign text.text_byte = out_byte;
  assign text.last_byte = out_last;

  // Output stage can take a byte when empty or being drained
  assign load  = !out_valid || text.ready;
  assign q_pop = load && (!busy || fin) && q_valid;

  // Pick the digit of the component in progress
  always_comb begin
    unique case (step)
      S_RDIG:  cur_dig = job.red.dig[didx];
      S_GDIG:  cur_dig = job.green.dig[didx];
      default: cur_dig = job.blue.dig[didx];
    endcase
  end

  // Byte for the current step, next step, and end-of-job flag
  always_comb begin
    cur_byte  = ate_pkg::CH_SPACE;
    step_next = step;
    didx_next = didx;
    fin       = 1'b0;
    unique case (step)
      S_ESC: begin
        cur_byte = ate_pkg::CH_ESC;
        step_next = S_LBR;
      end
      S_LBR: begin
        cur_byte = ate_pkg::CH_LBR;
        step_next = S_C4;
      end
      S_C4: begin
        cur_byte = ate_pkg::CH_FOUR;
        step_next = S_C8;
      end
      S_C8: begin
        cur_byte = ate_pkg::CH_EIGHT;
        step_next = S_SEMI1;
      end
      S_SEMI1: begin
        cur_byte = ate_pkg::CH_SEMI;
        step_next = S_C2;
      end
      S_C2: begin
        cur_byte = ate_pkg::CH_TWO;
        step_next = S_SEMI2;
      end
      S_SEMI2: begin
        cur_byte  = ate_pkg::CH_SEMI;
        step_next = S_RDIG;
        didx_next = job.red.top;
      end
      S_RDIG, S_GDIG, S_BDIG: begin
        cur_byte = ate_pkg::CH_ZERO | {4'd0, cur_dig};
        if (didx != 2'd0) begin
          didx_next = didx - 1'b1;
        end else begin
          unique case (step)
            S_RDIG:  step_next = S_SEMI3;
            S_GDIG:  step_next = S_SEMI4;
            default: step_next = S_M;
          endcase
        end
      end
      S_SEMI3: begin
        cur_byte  = ate_pkg::CH_SEMI;
        step_next = S_GDIG;
        didx_next = job.green.top;
      end
      S_SEMI4: begin
        cur_byte  = ate_pkg::CH_SEMI;
        step_next = S_BDIG;
        didx_next = job.blue.top;
      end
      S_M: begin
        cur_byte = ate_pkg::CH_M;
        step_next = S_SPACE;
      end
      S_SPACE: begin
        cur_byte  = ate_pkg::CH_SPACE;
        step_next = S_NL;
        fin       = !job.line_end;
      end
      S_NL: begin
        cur_byte  = ate_pkg::CH_NL;
        step_next = S_FESC;
        fin       = !job.frame_end;
      end
      S_FESC: begin
        cur_byte = ate_pkg::CH_ESC;
        step_next = S_FLBR;
      end
      S_FLBR: begin
        cur_byte = ate_pkg::CH_LBR;
        step_next = S_F0;
      end
      S_F0: begin
        cur_byte = ate_pkg::CH_ZERO;
        step_next = S_FM;
      end
      S_FM: begin
        cur_byte = ate_pkg::CH_M;
        fin      = 1'b1;
      end
      default: begin
        cur_byte = ate_pkg::CH_SPACE;
      end
    endcase
  end

  // Hold sequencer state and the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      step      <= S_SPACE;
      didx      <= 2'd0;
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= busy;
      if (busy) begin
        out_byte <= cur_byte;
        out_last <= fin;
      end
      if (q_pop) begin
        job  <= q_job;
        busy <= 1'b1;
        step <= q_job.emit_color ? S_ESC : S_SPACE;
        didx <= 2'd0;
      end else if (busy) begin
        step <= step_next;
        didx <= didx_next;
        if (fin) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

FILE: rtl/ansi_truecolor_pixel_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ansi_truecolor_pixel_encoder: RGB pixel to terminal text encoder
// Turns each pixel into a background color escape (when the color changes
// or a line starts), a space, and line and frame end bytes.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Carries                                          Transfer
//  pixel    in   red_level, green_level, blue_level, line_end,    valid & ready
//                frame_end
//  text     out  text_byte, last_byte                             valid & ready
//
//  One text byte leaves per cycle while the text channel is ready; a pixel
//  takes 1 to 25 output bytes (1 space, up to 19 color escape bytes,
//  newline, 4 frame end bytes), so the byte sequencer sets the throughput.
//  Pixels are classified on entry and wait in a two-entry job queue, so
//  input is taken while earlier pixels are still being sent.
//  Reset (rst, synchronous) clears the stored color, the queue and the
//  output stage. A stalled text channel holds its byte and fills the queue.
//
module ansi_truecolor_pixel_encoder (
  input  logic       clk,
  input  logic       rst,
  ate_pixel_if.sink  pixel,
  ate_text_if.source text
);

  ate_pkg::job_t push_job;
  ate_pkg::job_t head_job;
  logic          push;
  logic          full;
  logic          pop;
  logic          head_valid;

  ate_front u_front (
    .clk    (clk),
    .rst    (rst),
    .pixel  (pixel),
    .q_full (full),
    .q_push (push),
    .q_job  (push_job)
  );

  ate_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  ate_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (head_valid),
    .q_job   (head_job),
    .q_pop   (pop),
    .text    (text)
  );

endmodule

FILE: dv/pixel_text_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_text_checker: expected terminal text for the truecolor pixel encoder
// Watches the pixel and text channels. Each pixel transfer is turned into the
// bytes the encoder must send: color escape, space, newline, frame reset.
// Each text transfer is then compared in order against those bytes.
// ----------------------------------------------------------------------------
module pixel_text_checker (
  input  logic        clk,
  input  logic        rst,
  ate_pixel_if        pixel,
  ate_text_if         text,
  output int unsigned fail_count,
  output int unsigned open_bytes
);

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } text_item_t;

  // Bytes still owed by the encoder, oldest first
  text_item_t expected_text[$];
  // Bytes of the pixel being predicted
  logic [7:0] pixel_bytes[$];

  // Color state of the encoder
  logic       color_known;
  logic [7:0] last_red;
  logic [7:0] last_green;
  logic [7:0] last_blue;

  initial begin
    fail_count = 0;
    open_bytes = 0;
  end

  // Append a color component as 1 to 3 digits without leading zeros
  function automatic void add_decimal(logic [7:0] v);
    if (v >= 8'd100) pixel_bytes.push_back(ate_pkg::CH_ZERO + v / 8'd100);
    if (v >= 8'd10) pixel_bytes.push_back(ate_pkg::CH_ZERO + (v / 8'd10) % 8'd10);
    pixel_bytes.push_back(ate_pkg::CH_ZERO + v % 8'd10);
  endfunction

  // Work out the text of one pixel and queue it
  function automatic void predict_pixel_text(logic [7:0] r, logic [7:0] g,
                                             logic [7:0] b, logic le, logic fe);
    logic ends_line;
    ends_line = le | fe;
    pixel_bytes.delete();
    if (!color_known || r != last_red || g != last_green || b != last_blue) begin
      pixel_bytes.push_back(ate_pkg::CH_ESC);
      pixel_bytes.push_back(ate_pkg::CH_LBR);
      pixel_bytes.push_back(ate_pkg::CH_FOUR);
      pixel_bytes.push_back(ate_pkg::CH_EIGHT);
      pixel_bytes.push_back(ate_pkg::CH_SEMI);
      pixel_bytes.push_back(ate_pkg::CH_TWO);
      pixel_bytes.push_back(ate_pkg::CH_SEMI);
      add_decimal(r);
      pixel_bytes.push_back(ate_pkg::CH_SEMI);
      add_decimal(g);
      pixel_bytes.push_back(ate_pkg::CH_SEMI);
      add_decimal(b);
      pixel_bytes.push_back(ate_pkg::CH_M);
      color_known = 1'b1;
      last_red    = r;
      last_green  = g;
      last_blue   = b;
    end
    pixel_bytes.push_back(ate_pkg::CH_SPACE);
    // Line end forgets the color; frame end implies line end
    if (ends_line) begin
      pixel_bytes.push_back(ate_pkg::CH_NL);
      color_known = 1'b0;
    end
    if (fe) begin
      pixel_bytes.push_back(ate_pkg::CH_ESC);
      pixel_bytes.push_back(ate_pkg::CH_LBR);
      pixel_bytes.push_back(ate_pkg::CH_ZERO);
      pixel_bytes.push_back(ate_pkg::CH_M);
    end
    foreach (pixel_bytes[i]) begin
      expected_text.push_back('{code: pixel_bytes[i],
                                last: (i == pixel_bytes.size() - 1)});
    end
  endfunction

  // Predict on pixel transfers, compare on text transfers
  always @(posedge clk) begin
    text_item_t want;
    if (rst) begin
      expected_text.delete();
      color_known = 1'b0;
      last_red    = 8'd0;
      last_green  = 8'd0;
      last_blue   = 8'd0;
    end else begin
      if (pixel.valid && pixel.ready) begin
        predict_pixel_text(pixel.red_level, pixel.green_level, pixel.blue_level,
                           pixel.line_end, pixel.frame_end);
      end
      if (text.valid && text.ready) begin
        if (expected_text.size() == 0) begin
          $error("text transfer with nothing expected: text_byte %02h last_byte %0b",
                 text.text_byte, text.last_byte);
          fail_count++;
        end else begin
          want = expected_text.pop_front();
          if (text.text_byte !== want.code) begin
            $error("text_byte: expected %02h, actual %02h", want.code, text.text_byte);
            fail_count++;
          end
          if (text.last_byte !== want.last) begin
            $error("last_byte: expected %0b, actual %0b", want.last, text.last_byte);
            fail_count++;
          end
        end
      end
    end
    open_bytes = expected_text.size();
  end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the truecolor pixel encoder
// Sends directed pixels (digit counts, repeated colors, line and frame ends)
// and then random rows of pixels, with random stalls on both channels. The
// checker predicts and compares the text; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

  logic        clk;
  logic        rst;
  logic        calm;
  int unsigned fail_count;
  int unsigned open_bytes;
  int unsigned hold_left;
  int unsigned steady_left;

  ate_pixel_if pixel_ch ();
  ate_text_if  text_ch ();

  ansi_truecolor_pixel_encoder dut (
    .clk   (clk),
    .rst   (rst),
    .pixel (pixel_ch),
    .text  (text_ch)
  );

  pixel_text_checker text_check (
    .clk        (clk),
    .rst        (rst),
    .pixel      (pixel_ch),
    .text       (text_ch),
    .fail_count (fail_count),
    .open_bytes (open_bytes)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Give up if the run hangs
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Stall the text channel in bursts of random length, with calm stretches
  always @(negedge clk) begin
    if (calm) begin
      text_ch.ready <= 1'b1;
    end else if (hold_left != 0) begin
      text_ch.ready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (steady_left != 0) begin
      text_ch.ready <= 1'b1;
      steady_left   <= steady_left - 1;
    end else if ($urandom_range(0, 31) == 0) begin
      text_ch.ready <= 1'b1;
      steady_left   <= $urandom_range(20, 60);
    end else if ($urandom_range(0, 7) == 0) begin
      text_ch.ready <= 1'b0;
      hold_left     <= $urandom_range(0, 15);
    end else begin
      text_ch.ready <= 1'b1;
    end
  end

  // Offer one pixel after an optional gap and hold it until the transfer
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                            logic le, logic fe);
    if (!calm && $urandom_range(0, 3) == 0) begin
      pixel_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    pixel_ch.valid       <= 1'b1;
    pixel_ch.red_level   <= r;
    pixel_ch.green_level <= g;
    pixel_ch.blue_level  <= b;
    pixel_ch.line_end    <= le;
    pixel_ch.frame_end   <= fe;
    do @(posedge clk); while (!pixel_ch.ready);
    @(negedge clk);
  endtask

  // Pick a level with 1, 2 or 3 decimal digits
  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 2))
      0:       return 8'($urandom_range(0, 9));
      1:       return 8'($urandom_range(10, 99));
      default: return 8'($urandom_range(100, 255));
    endcase
  endfunction

  initial begin
    logic [7:0]  r, g, b;
    logic        le, fe, frame_close;
    int unsigned line_len;
    int unsigned sent;

    rst                  = 1'b1;
    calm                 = 1'b0;
    hold_left            = 0;
    steady_left          = 0;
    text_ch.ready        = 1'b0;
    pixel_ch.valid       = 1'b0;
    pixel_ch.red_level   = 8'd0;
    pixel_ch.green_level = 8'd0;
    pixel_ch.blue_level  = 8'd0;
    pixel_ch.line_end    = 1'b0;
    pixel_ch.frame_end   = 1'b0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: first color, repeats, digit counts, line and frame ends
    send_pixel(8'd0,   8'd0,   8'd0,   1'b0, 1'b0);
    send_pixel(8'd0,   8'd0,   8'd0,   1'b0, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b0);
    send_pixel(8'd9,   8'd10,  8'd99,  1'b0, 1'b0);
    send_pixel(8'd100, 8'd199, 8'd250, 1'b0, 1'b0);
    send_pixel(8'd100, 8'd199, 8'd250, 1'b1, 1'b0);
    send_pixel(8'd100, 8'd199, 8'd250, 1'b0, 1'b0);
    send_pixel(8'd1,   8'd2,   8'd3,   1'b0, 1'b1);
    send_pixel(8'd1,   8'd2,   8'd3,   1'b0, 1'b0);
    send_pixel(8'd1,   8'd2,   8'd3,   1'b1, 1'b1);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1, 1'b1);
    send_pixel(8'd170, 8'd85,  8'd170, 1'b0, 1'b0);
    send_pixel(8'd85,  8'd170, 8'd85,  1'b1, 1'b0);
    send_pixel(8'd128, 8'd64,  8'd32,  1'b0, 1'b0);
    send_pixel(8'd127, 8'd64,  8'd32,  1'b0, 1'b0);
    send_pixel(8'd127, 8'd65,  8'd32,  1'b0, 1'b0);
    send_pixel(8'd127, 8'd65,  8'd33,  1'b0, 1'b0);
    send_pixel(8'd127, 8'd65,  8'd33,  1'b1, 1'b1);

    // Random rows: runs of equal colors, mostly well-formed line ends
    sent = 0;
    r    = pick_level();
    g    = pick_level();
    b    = pick_level();
    while (sent < 280) begin
      line_len    = $urandom_range(1, 12);
      frame_close = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < line_len; i++) begin
        if ($urandom_range(0, 1) == 0) begin
          r = pick_level();
          g = pick_level();
          b = pick_level();
        end else if ($urandom_range(0, 5) == 0) begin
          r = r ^ (8'd1 << $urandom_range(0, 7));
        end
        le = (i == line_len - 1);
        fe = le && frame_close;
        // Inject stray frame ends and broken line marks
        if ($urandom_range(0, 24) == 0) fe = 1'b1;
        if ($urandom_range(0, 19) == 0) le = ~le;
        calm = (sent >= 240);
        send_pixel(r, g, b, le, fe);
        sent++;
      end
    end
    pixel_ch.valid <= 1'b0;

    // Drain
    while (open_bytes != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/ate_pkg.sv
rtl/ate_pixel_if.sv
rtl/ate_text_if.sv
rtl/ate_front.sv
rtl/ate_queue.sv
rtl/ate_back.sv
rtl/ansi_truecolor_pixel_encoder.sv
dv/pixel_text_checker.sv
dv/tb_top.sv
